### rtl/autokey_xor_byte_cipher_assert.svh
// ----------------------------------------------------------------------------
// autokey xor byte cipher assertion macros
// shared assertion wrappers clocked on clk_i, AXB_ASSERT disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef AUTOKEY_XOR_BYTE_CIPHER_ASSERT_SVH
`define AUTOKEY_XOR_BYTE_CIPHER_ASSERT_SVH

// checked only outside reset
`define AXB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define AXB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/axb_pkg.sv
// ----------------------------------------------------------------------------
// axb_pkg
// types, constants and helper functions of the autokey xor byte cipher
// ----------------------------------------------------------------------------
`default_nettype none

package axb_pkg;

  // sizes
  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_REG_BYTES = 16;
  localparam int DATA_W        = 8;
  localparam int REG_W         = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int IDX_W         = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CNT_W         = IDX_W + 1;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW   = 2'd0,
    REG_KEY_HIGH  = 2'd1,
    REG_KEY_LEN   = 2'd2,
    REG_DIRECTION = 2'd3
  } cfg_reg_e;

  // register contents handed to the datapath
  typedef struct packed {
    logic [REG_W-1:0]     key_low;
    logic [REG_W-1:0]     key_high;
    logic [KEY_LEN_W-1:0] key_len;
    logic                 unlock;
  } cfg_t;

  // key byte i as loaded from the key registers
  function automatic logic [DATA_W-1:0] cfg_key_byte(input cfg_t cfg,
                                                     input logic [IDX_W-1:0] idx);
    int sel;
    sel = int'(idx);
    if (sel < 8) begin
      return cfg.key_low[DATA_W*sel +: DATA_W];
    end else if (sel < KEY_REG_BYTES) begin
      return cfg.key_high[DATA_W*(sel-8) +: DATA_W];
    end else begin
      return '0;
    end
  endfunction

  // key length clamped to 1 .. MAX_KEY_BYTES
  function automatic logic [CNT_W-1:0] eff_len(input logic [KEY_LEN_W-1:0] klen);
    if (klen == '0) begin
      return CNT_W'(1);
    end else if (int'(klen) > MAX_KEY_BYTES) begin
      return CNT_W'(MAX_KEY_BYTES);
    end else begin
      return CNT_W'(klen);
    end
  endfunction

endpackage

`default_nettype wire

### rtl/axb_if.sv
// ----------------------------------------------------------------------------
// axb channel interfaces
// valid/ready channels for input bytes, output bytes and register writes
// ----------------------------------------------------------------------------
`default_nettype none

// input byte channel
interface axb_in_if import axb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_in;
  logic              stream_start;

  modport source (output valid, output data_in, output stream_start, input ready);
  modport sink   (input valid, input data_in, input stream_start, output ready);
endinterface

// output byte channel
interface axb_out_if import axb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// register write channel
interface axb_cfg_if import axb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/axb_cfg_regs.sv
// ----------------------------------------------------------------------------
// axb_cfg_regs
// configuration register file: key bytes, key length and direction
// ----------------------------------------------------------------------------
`default_nettype none

module axb_cfg_regs import axb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  axb_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t     cfg_q;
  cfg_reg_e reg_sel;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign reg_sel     = cfg_reg_e'(cfg_i.index);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_low  <= '0;
      cfg_q.key_high <= '0;
      cfg_q.key_len  <= KEY_LEN_RESET;
      cfg_q.unlock   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (reg_sel)
        REG_KEY_LOW:   cfg_q.key_low  <= cfg_i.data;
        REG_KEY_HIGH:  cfg_q.key_high <= cfg_i.data;
        REG_KEY_LEN:   cfg_q.key_len  <= cfg_i.data[KEY_LEN_W-1:0];
        REG_DIRECTION: cfg_q.unlock   <= cfg_i.data[0];
        default:       cfg_q.unlock   <= cfg_q.unlock;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/axb_core.sv
// ----------------------------------------------------------------------------
// axb_core
// keystream datapath: xor with the current key byte, self-updating key
// ----------------------------------------------------------------------------
`default_nettype none

module axb_core import axb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  axb_in_if.sink     in_i,
  axb_out_if.source  out_o
);

  logic [DATA_W-1:0] wk_q [MAX_KEY_BYTES];
  logic [IDX_W-1:0]  key_idx_q, key_idx_d;
  logic [DATA_W-1:0] cur_key_q, cur_key_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] data_out_q, data_out_d;

  logic              accept;
  logic [IDX_W-1:0]  base_idx;
  logic [DATA_W-1:0] base_key;
  logic [DATA_W-1:0] feed;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  idx_inc;
  logic [DATA_W-1:0] old_next;

  // output register frees as soon as it is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // key byte at the current index; cur_key_q always mirrors wk_q[key_idx_q]
  always_comb begin
    base_idx   = in_i.stream_start ? '0 : key_idx_q;
    base_key   = in_i.stream_start ? cfg_key_byte(cfg_i, '0) : cur_key_q;
    data_out_d = in_i.data_in ^ base_key;
    feed       = cfg_i.unlock ? in_i.data_in : data_out_d;
  end

  // index advance with wrap at the key length
  always_comb begin
    len     = eff_len(cfg_i.key_len);
    idx_inc = CNT_W'(base_idx) + CNT_W'(1);
    if (idx_inc >= len) begin
      key_idx_d = '0;
    end else begin
      key_idx_d = idx_inc[IDX_W-1:0];
    end
  end

  // key update at the new index
  always_comb begin
    old_next  = in_i.stream_start ? cfg_key_byte(cfg_i, key_idx_d) : wk_q[key_idx_d];
    cur_key_d = old_next + feed;
  end

  // working key, index and mirrored key byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        wk_q[i] <= '0;
      end
      key_idx_q <= '0;
      cur_key_q <= '0;
    end else if (accept) begin
      // updated entry takes the sum, the rest reload on a stream start
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
        if (IDX_W'(i) == key_idx_d) begin
          wk_q[i] <= cur_key_d;
        end else if (in_i.stream_start) begin
          wk_q[i] <= cfg_key_byte(cfg_i, IDX_W'(i));
        end
      end
      key_idx_q <= key_idx_d;
      cur_key_q <= cur_key_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // output byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_out_q <= data_out_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = data_out_q;

endmodule

`default_nettype wire

### rtl/autokey_xor_byte_cipher.sv
// Latency: a byte accepted at one edge shows its result at the output from the next cycle.
// Throughput: one byte per cycle while the output is not held off; the key read, add and write-back at the next index
// completes within the accepting cycle and is forwarded to the following byte.
// Reset: rst_ni clears the working key to zeros, the index to 0, the output valid,
// the key registers and direction to 0 and the key length to 16.
// ----------------------------------------------------------------------------
// autokey_xor_byte_cipher
// byte stream cipher with a self-modifying key, top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "autokey_xor_byte_cipher_assert.svh"

module autokey_xor_byte_cipher import axb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  axb_in_if.sink     in_i,
  axb_out_if.source  out_o,
  axb_cfg_if.sink    cfg_i
);

  cfg_t cfg;

  // configuration registers
  axb_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // cipher datapath
  axb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // every accepted transaction yields a result on the next cycle
  `AXB_ASSERT(a_accept_gives_result, in_i.valid && in_i.ready |=> out_o.valid,
              "accepted byte produced no result")

  // input stalls only behind a held result
  `AXB_ASSERT(a_stall_only_on_backpressure, !in_i.ready |-> out_o.valid && !out_o.ready,
              "input stalled without output backpressure")

  // no result during reset
  `AXB_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_o.valid,
                     "output valid during reset")

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the autokey xor byte cipher: a cycle-free predictor
// tracks the working key, index and registers, and every output byte is
// checked in order against it under random input gaps and output stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import axb_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 750;

  logic clk_i;
  logic rst_ni = 1'b1;

  axb_in_if  in_if ();
  axb_out_if out_if ();
  axb_cfg_if cfg_if ();

  autokey_xor_byte_cipher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state: register copies, working key and index
  logic [REG_W-1:0]     key_low_m;
  logic [REG_W-1:0]     key_high_m;
  logic [KEY_LEN_W-1:0] key_len_m;
  logic                 unlock_m;
  logic [DATA_W-1:0]    key_ring [MAX_KEY_BYTES];
  int                   key_pos;

  logic [DATA_W-1:0] expected_bytes [$];
  int  fail_cnt = 0;
  bit  pace_en = 1'b1;
  bit  hold_req = 1'b0;
  int  burst_left = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // encrypt or decrypt one byte and advance the self-modifying key
  function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] din,
                                                    input logic start);
    logic [DATA_W-1:0] dout;
    logic [DATA_W-1:0] feed;
    int len;
    int i;
    if (start) begin
      for (i = 0; i < MAX_KEY_BYTES; i++) begin
        if (i < 8) begin
          key_ring[i] = key_low_m[8*i +: 8];
        end else if (i < 16) begin
          key_ring[i] = key_high_m[8*(i-8) +: 8];
        end else begin
          key_ring[i] = '0;
        end
      end
      key_pos = 0;
    end
    dout = din ^ key_ring[key_pos];
    feed = unlock_m ? din : dout;
    // length is read on every byte, zero means one, large values saturate
    len = int'(key_len_m);
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    key_pos = key_pos + 1;
    if (key_pos >= len) key_pos = 0;
    key_ring[key_pos] = key_ring[key_pos] + feed;
    return dout;
  endfunction

  // one register write transaction
  task automatic write_reg(input cfg_reg_e idx, input logic [REG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_KEY_LOW:   key_low_m  = value;
      REG_KEY_HIGH:  key_high_m = value;
      REG_KEY_LEN:   key_len_m  = value[KEY_LEN_W-1:0];
      REG_DIRECTION: unlock_m   = value[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_config(input logic [REG_W-1:0] low, input logic [REG_W-1:0] high,
                              input logic [KEY_LEN_W-1:0] len, input logic unlock);
    write_reg(REG_KEY_LOW, low);
    write_reg(REG_KEY_HIGH, high);
    write_reg(REG_KEY_LEN, REG_W'(len));
    write_reg(REG_DIRECTION, REG_W'(unlock));
  endtask

  // one input byte transaction, followed by a random gap at the end of a burst when pacing is on
  task automatic send_byte(input logic [DATA_W-1:0] din, input logic start);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.data_in      <= din;
    in_if.stream_start <= start;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_bytes.push_back(cipher_byte(din, start));
    if (pace_en) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                 : $urandom_range(1, 24);
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // stop offering and let every pending byte come out
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // bytes before any stream start use the reset key
  task automatic test_reset_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    wait_results_done();
  endtask

  task automatic test_lock_stream();
    write_config(64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef, 5'd16, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_results_done();
  endtask

  task automatic test_unlock_stream();
    write_reg(REG_DIRECTION, REG_W'(1));
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b0);
    wait_results_done();
  endtask

  // zero length behaves as one, the index stays on entry zero
  task automatic test_zero_length();
    write_config(64'h8877_6655_4433_2211, 64'h0, 5'd0, 1'b0);
    send_byte(8'h3c, 1'b1);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h99, 1'b0);
    wait_results_done();
  endtask

  // length shrunk under the index, key and direction changed inside a stream
  task automatic test_midstream_config();
    write_config(64'h0f1e_2d3c_4b5a_6978, 64'hf0e1_d2c3_b4a5_9687, 5'd16, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
    wait_results_done();
    write_reg(REG_KEY_LEN, REG_W'(3));
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b0);
    wait_results_done();
    write_reg(REG_KEY_LOW, 64'hdead_beef_cafe_f00d);
    write_reg(REG_DIRECTION, REG_W'(1));
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    wait_results_done();
  endtask

  // output held off while input keeps coming, the block must stall its input
  task automatic test_backpressure();
    int k;
    write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'd7, 1'b0);
    pace_en  = 1'b0;
    hold_req = 1'b1;
    send_byte(8'($urandom), 1'b1);
    for (k = 0; k < 47; k++) begin
      send_byte(8'($urandom), 1'b0);
    end
    pace_en = 1'b1;
    wait_results_done();
  endtask

  task automatic random_config();
    logic [REG_W-1:0] low;
    logic [REG_W-1:0] high;
    logic [KEY_LEN_W-1:0] len;
    case ($urandom_range(0, 5))
      0: begin low = '0; high = '0; end
      1: begin low = '1; high = '1; end
      default: begin low = {$urandom, $urandom}; high = {$urandom, $urandom}; end
    endcase
    case ($urandom_range(0, 9))
      0: len = 5'd1;
      1: len = 5'd16;
      2: len = 5'($urandom_range(0, 31));
      default: len = 5'($urandom_range(1, 16));
    endcase
    write_config(low, high, len, 1'($urandom_range(0, 1)));
  endtask

  // random streams over many settings, a few length changes between streams
  task automatic test_random_streams();
    int sent;
    int n_streams;
    int stream_len;
    int k;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_results_done();
      random_config();
      n_streams = $urandom_range(2, 6);
      repeat (n_streams) begin
        if ($urandom_range(0, 4) == 0) begin
          wait_results_done();
          write_reg(REG_KEY_LEN, REG_W'($urandom_range(0, 31)));
        end
        stream_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
        send_byte(8'($urandom), ($urandom_range(0, 9) != 0));
        for (k = 1; k < stream_len; k++) begin
          send_byte(8'($urandom), ($urandom_range(0, 19) == 0));
        end
        sent += stream_len;
      end
    end
    wait_results_done();
  endtask

  // output ready: random patterns in stretches, plus a long hold on request
  initial begin : receiver
    int mode;
    int stretch;
    int hold_left;
    out_if.ready <= 1'b0;
    mode = 0;
    stretch = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(8, 80);
      end
      stretch--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each output transaction with the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte, expected none, actual %02h",
                 $time, out_if.data_out);
        fail_cnt++;
      end else begin
        if (out_if.data_out !== expected_bytes[0]) begin
          $display("%0t: data_out mismatch, expected %02h, actual %02h",
                   $time, expected_bytes[0], out_if.data_out);
          fail_cnt++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // main sequence
  initial begin
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.data_in      <= '0;
    in_if.stream_start <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_KEY_LOW;
    cfg_if.data        <= '0;
    key_low_m  = '0;
    key_high_m = '0;
    key_len_m  = 5'd16;
    unlock_m   = 1'b0;
    key_pos    = 0;
    foreach (key_ring[i]) key_ring[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_lock_stream();
    test_unlock_stream();
    test_zero_length();
    test_midstream_config();
    test_backpressure();
    test_random_streams();
    wait_results_done();
    if (fail_cnt == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/axb_pkg.sv
rtl/axb_if.sv
rtl/axb_cfg_regs.sv
rtl/axb_core.sv
rtl/autokey_xor_byte_cipher.sv
dv/tb.sv
